// File: hdl/buffered_store_concentration_step_core_macros.svh
// assertion macros used by the checker file
`ifndef BUFFERED_STORE_CONCENTRATION_STEP_CORE_MACROS_SVH
`define BUFFERED_STORE_CONCENTRATION_STEP_CORE_MACROS_SVH

// same-cycle implication
`define BSCS_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSCS_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bscs_pkg.sv
// package: shared types and constants of the buffered store concentration step
package bscs_pkg;

  localparam int NUNITS_DEF = 64;
  localparam int NIONS_DEF  = 2;

  // divider widths
  localparam int DIV_W    = 78;
  localparam int DIV_LO_W = 48;
  localparam int DIV_CW   = 6;

  localparam logic [5:0] BUF_STEPS   = 6'd48;
  localparam logic [5:0] EULER_STEPS = 6'd33;

  localparam logic [49:0] BETA_ONE = 50'd65536;
  localparam logic [49:0] TERM_MAX = 50'h0_FFFF_FFFF_FFFF;
  localparam logic [31:0] CONC_MAX = 32'hFFFF_FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_BUFFER_TOTAL  = 3'd0,
    REG_CURRENT_SCALE = 3'd1,
    REG_DISSOC_PAIR   = 3'd2,
    REG_BINDING_SITES = 3'd3,
    REG_REFILL_RATE   = 3'd4,
    REG_INITIAL_PAIR  = 3'd5,
    REG_HOLD          = 3'd6
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_READ, S_LOAD,
    S_BM1, S_BM2, S_BDIV, S_BWAIT,
    S_DM1, S_DM2, S_DM3, S_DM4, S_DM5, S_DM6, S_DM7,
    S_DDIV, S_DWAIT, S_WRITE, S_DONE
  } state_t;

  // divider request
  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
    logic [DIV_W-1:0]  rem_init;
    logic [DIV_LO_W-1:0] num_lo;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

endpackage

// File: hdl/bscs_ram.sv
// generic single-port-write ram with registered read
module bscs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bscs_mul.sv
// shared multiplier with registered product
module bscs_mul (
  input  logic        clk,
  input  logic [35:0] a,
  input  logic [32:0] b,
  output logic [68:0] p
);

  always_ff @(posedge clk) begin
    p <= 69'(a) * 69'(b);
  end

endmodule

// File: hdl/bscs_div.sv
// restoring radix-2 divider, one quotient bit per cycle
module bscs_div import bscs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  div_req_t            req,
  output logic                done,
  output logic [DIV_LO_W-1:0] quot
);

  logic              active;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_LO_W-1:0] lo;
  logic [DIV_W:0]    rem2;
  logic              ge;

  // trial subtract
  always_comb begin
    rem2 = {rem, lo[DIV_LO_W-1]};
    ge   = rem2 >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= req.steps;
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem_init;
      lo   <= req.num_lo;
      dvs  <= req.divisor;
      quot <= '0;
    end else if (active) begin
      rem  <= ge ? DIV_W'(rem2 - {1'b0, dvs}) : rem2[DIV_W-1:0];
      lo   <= {lo[DIV_LO_W-2:0], 1'b0};
      quot <= {quot[DIV_LO_W-2:0], ge};
    end
  end

endmodule

// File: hdl/buffered_store_concentration_step_core.sv
// top level: buffered store concentration step
//
// Input stream s_axis: one item per transfer. tuser is the mode (0 advance a
// unit, 1 reload every unit with the initial pair). Output stream m_axis: one
// result per item, unit and both concentrations in tdata, clamp flag in tuser.
// Config port: cfg_we/cfg_index/cfg_data, to be written only while the block
// idles; the block itself does not enforce this. An advance item runs per ion
// a buffer term (a 48-bit divide on the shared divider) and an Euler update
// (a 33-bit divide), all on one shared multiplier and one shared divider.
// A zero buffer denominator, a saturated term or a saturated update skips
// its divide. Hold items and out-of-range units skip the computation, and a
// reload item sweeps the store.
// s_axis_tready is high only while the sequencer idles; one finished result
// waits in the output register, so the next item is taken while the receiver
// stalls, and that item finishes and waits until the register drains.
// After rst the store is swept to zero with tready low.
module buffered_store_concentration_step_core import bscs_pkg::*; #(
  parameter int NUNITS = NUNITS_DEF,
  parameter int NIONS  = NIONS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // unit, time_step, release_current_0, release_current_1,
  // refill_conc_0, refill_conc_1, zero pad
  input  logic [159:0] s_axis_tdata,
  // mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // unit_out, conc_0, conc_1, zero pad
  output logic [71:0]  m_axis_tdata,
  // clamped
  output logic         m_axis_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int AW = (NUNITS > 1) ? $clog2(NUNITS) : 1;
  localparam logic LAST_ION = 1'(NIONS - 1);

  // configuration
  logic [31:0] buffer_total, current_scale;
  logic [63:0] dissoc_pair, refill_rate_pair, initial_pair;
  logic [7:0]  binding_sites;
  logic        hold;

  // item
  logic        mode_r;
  logic [5:0]  unit_r;
  logic [23:0] dt_r;
  logic [31:0] cur0, cur1, refill0, refill1;

  // working state
  state_t      state, state_next;
  logic [AW-1:0] clr_addr;
  logic        clr_item;
  logic        ion;
  logic        ion_step;
  logic [31:0] c0, c1, res0, res1;
  logic        clamped_r;
  logic [49:0] beta;
  logic [35:0] num_hi;
  logic [47:0] num_lo;
  logic signed [66:0] acc;
  logic [65:0] mag;
  logic        dneg;
  logic [88:0] ndt;

  // shared units
  logic [35:0] mul_a;
  logic [32:0] mul_b;
  logic [68:0] mul_p;
  div_req_t    div_req;
  logic        div_done;
  logic [47:0] div_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, unit_addr;
  logic [63:0]   ram_wdata, ram_rdata;

  // output register
  logic        out_valid;
  logic [5:0]  out_unit;
  logic [31:0] out_c0, out_c1;
  logic        out_clamped;

  // per-ion selection
  logic [31:0] k_j, rate_j, refill_j, cur_j, c_j;
  logic [3:0]  sites_j;
  logic [32:0] s_j;
  logic [31:0] cmag;
  logic        cneg;
  logic [66:0] drive_new;
  logic        in_xfer, in_range, bsat, dsat;
  logic [15:0] in_unit_ext;
  logic [32:0] q33;

  always_comb begin
    k_j      = ion ? dissoc_pair[63:32] : dissoc_pair[31:0];
    rate_j   = ion ? refill_rate_pair[63:32] : refill_rate_pair[31:0];
    sites_j  = ion ? binding_sites[7:4] : binding_sites[3:0];
    refill_j = ion ? refill1 : refill0;
    cur_j    = ion ? cur1 : cur0;
    c_j      = ion ? c1 : c0;
    s_j      = {1'b0, k_j} + {1'b0, c_j};
    cneg     = cur_j[31];
    cmag     = cneg ? 32'(33'h1_0000_0000 - {1'b0, cur_j}) : cur_j;
    drive_new = cneg ? 67'(acc + signed'({3'b0, mul_p[63:0]}))
                     : 67'(acc - signed'({3'b0, mul_p[63:0]}));
    in_xfer   = s_axis_tvalid && s_axis_tready;
    in_unit_ext = {10'b0, s_axis_tdata[5:0]};
    in_range  = in_unit_ext < 16'(NUNITS);
    unit_addr = AW'({10'b0, unit_r});
    bsat = {30'b0, num_hi} >= mul_p[65:0];
    dsat = {22'b0, ndt[88:33]} >= {beta, 28'b0};
    q33  = div_q[32:0];
  end

  bscs_ram #(.WIDTH(64), .DEPTH(NUNITS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(unit_addr), .rdata(ram_rdata)
  );

  bscs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  bscs_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quot(div_q));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_total     <= '0;
      current_scale    <= '0;
      dissoc_pair      <= '0;
      binding_sites    <= '0;
      refill_rate_pair <= '0;
      initial_pair     <= '0;
      hold             <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BUFFER_TOTAL:  buffer_total     <= cfg_data[31:0];
        REG_CURRENT_SCALE: current_scale    <= cfg_data[31:0];
        REG_DISSOC_PAIR:   dissoc_pair      <= cfg_data;
        REG_BINDING_SITES: binding_sites    <= cfg_data[7:0];
        REG_REFILL_RATE:   refill_rate_pair <= cfg_data;
        REG_INITIAL_PAIR:  initial_pair     <= cfg_data;
        REG_HOLD:          hold             <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and unit controls
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = unit_addr;
    ram_wdata  = {res1, res0};
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    ion_step   = 1'b0;
    s_axis_tready = (state == S_IDLE);
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = initial_pair;
        if (clr_addr == AW'(NUNITS - 1)) begin
          state_next = clr_item ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser) begin
            state_next = S_CLEAR;
          end else if (in_range) begin
            state_next = S_READ;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_READ: state_next = S_LOAD;
      S_LOAD: state_next = hold ? S_DONE : S_BM1;
      S_BM1: begin
        if (s_j == '0) begin
          ion_step   = 1'b1;
          state_next = (ion == LAST_ION) ? S_DM1 : S_BM1;
        end else begin
          mul_a      = 36'({4'b0, k_j} * {32'b0, sites_j});
          mul_b      = {1'b0, buffer_total};
          state_next = S_BM2;
        end
      end
      S_BM2: begin
        mul_a      = {3'b0, s_j};
        mul_b      = s_j;
        state_next = S_BDIV;
      end
      S_BDIV: begin
        if (bsat) begin
          ion_step   = 1'b1;
          state_next = (ion == LAST_ION) ? S_DM1 : S_BM1;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = BUF_STEPS;
          div_req.rem_init = DIV_W'(num_hi);
          div_req.num_lo   = num_lo;
          div_req.divisor  = DIV_W'(mul_p[65:0]);
          state_next       = S_BWAIT;
        end
      end
      S_BWAIT: begin
        if (div_done) begin
          ion_step   = 1'b1;
          state_next = (ion == LAST_ION) ? S_DM1 : S_BM1;
        end
      end
      S_DM1: begin
        mul_a = {4'b0, rate_j};
        mul_b = {1'b0, refill_j};
        state_next = S_DM2;
      end
      S_DM2: begin
        mul_a = {4'b0, rate_j};
        mul_b = {1'b0, c_j};
        state_next = S_DM3;
      end
      S_DM3: begin
        mul_a = {4'b0, cmag};
        mul_b = {1'b0, current_scale};
        state_next = S_DM4;
      end
      S_DM4: state_next = S_DM5;
      S_DM5: begin
        mul_a = {12'b0, dt_r};
        mul_b = mag[32:0];
        state_next = S_DM6;
      end
      S_DM6: begin
        mul_a = {12'b0, dt_r};
        mul_b = mag[65:33];
        state_next = S_DM7;
      end
      S_DM7: state_next = S_DDIV;
      S_DDIV: begin
        if (dsat) begin
          ion_step   = 1'b1;
          state_next = (ion == LAST_ION) ? S_WRITE : S_DM1;
        end else begin
          div_req.start    = 1'b1;
          div_req.steps    = EULER_STEPS;
          div_req.rem_init = DIV_W'(ndt[88:33]);
          div_req.num_lo   = {ndt[32:0], 15'b0};
          div_req.divisor  = {beta, 28'b0};
          state_next       = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          ion_step   = 1'b1;
          state_next = (ion == LAST_ION) ? S_WRITE : S_DM1;
        end
      end
      S_WRITE: begin
        ram_we     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_item <= 1'b0;
      ion      <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else if (in_xfer) begin
        clr_addr <= '0;
        clr_item <= 1'b1;
      end
      if (state == S_LOAD) begin
        ion <= 1'b0;
      end else if (ion_step) begin
        ion <= (ion == LAST_ION) ? 1'b0 : ~ion;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          mode_r    <= s_axis_tuser;
          unit_r    <= s_axis_tdata[5:0];
          dt_r      <= s_axis_tdata[29:6];
          cur0      <= s_axis_tdata[61:30];
          cur1      <= s_axis_tdata[93:62];
          refill0   <= s_axis_tdata[125:94];
          refill1   <= s_axis_tdata[157:126];
          res0      <= s_axis_tuser ? initial_pair[31:0] : '0;
          res1      <= s_axis_tuser ? initial_pair[63:32] : '0;
          clamped_r <= 1'b0;
        end
      end
      S_LOAD: begin
        c0   <= ram_rdata[31:0];
        c1   <= ram_rdata[63:32];
        res0 <= ram_rdata[31:0];
        res1 <= ram_rdata[63:32];
        beta <= BETA_ONE;
      end
      S_BM2: begin
        num_hi <= mul_p[67:32];
        num_lo <= {mul_p[31:0], 16'b0};
      end
      S_BDIV: begin
        if (bsat) begin
          beta <= beta + TERM_MAX;
        end
      end
      S_BWAIT: begin
        if (div_done) begin
          beta <= beta + {2'b0, div_q};
        end
      end
      S_DM2: acc <= signed'({3'b0, mul_p[63:0]});
      S_DM3: acc <= acc - signed'({3'b0, mul_p[63:0]});
      S_DM4: begin
        dneg <= drive_new[66];
        mag  <= drive_new[66] ? 66'(67'(0) - drive_new) : drive_new[65:0];
      end
      S_DM6: ndt <= {32'b0, mul_p[56:0]};
      S_DM7: ndt <= ndt + {mul_p[55:0], 33'b0};
      S_DDIV: begin
        if (dsat) begin
          clamped_r <= 1'b1;
          if (ion) begin
            res1 <= dneg ? '0 : CONC_MAX;
          end else begin
            res0 <= dneg ? '0 : CONC_MAX;
          end
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          if (dneg) begin
            if (q33 > {1'b0, c_j}) begin
              clamped_r <= 1'b1;
              if (ion) res1 <= '0; else res0 <= '0;
            end else if (ion) begin
              res1 <= c_j - q33[31:0];
            end else begin
              res0 <= c_j - q33[31:0];
            end
          end else begin
            if (q33 > {1'b0, CONC_MAX - c_j}) begin
              clamped_r <= 1'b1;
              if (ion) res1 <= CONC_MAX; else res0 <= CONC_MAX;
            end else if (ion) begin
              res1 <= c_j + q33[31:0];
            end else begin
              res0 <= c_j + q33[31:0];
            end
          end
        end
      end
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_unit    <= unit_r;
          out_c0      <= res0;
          out_c1      <= (NIONS > 1) ? res1 : '0;
          out_clamped <= clamped_r && !mode_r;
        end
      end
      default: ;
    endcase
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || m_axis_tready)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b0, out_c1, out_c0, out_unit};
  assign m_axis_tuser  = out_clamped;

endmodule

// File: hdl/bscs_checker.sv
// port-level checker for the concentration step core, with its bind
`include "buffered_store_concentration_step_core_macros.svh"

module bscs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // reset starts the store sweep and empties the output
  `BSCS_ASSERT_NXT(a_reset_busy, clk, 1'b0, rst, !s_axis_tready && !m_axis_tvalid, "busy after reset")
  // an accepted item keeps the block busy next cycle
  `BSCS_ASSERT_NXT(a_item_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after transfer")
  // stalled result holds
  `BSCS_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed under stall")

endmodule

bind buffered_store_concentration_step_core bscs_checker u_bscs_checker (.*);
